// ===== src/feedback_echo_delay_top_defines.svh =====
// Assertion macros shared by the echo delay RTL.
`ifndef FEEDBACK_ECHO_DELAY_TOP_DEFINES_SVH
`define FEEDBACK_ECHO_DELAY_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define FED_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define FED_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/fed_pkg.sv =====
// Shared constants and types of the feedback echo delay block.
package fed_pkg;

   localparam int STORE_DEPTH = 32768;
   localparam int SAMPLE_W    = 16;
   localparam int STORE_W     = 25;
   localparam int LAST_W      = 15;
   localparam int GAIN_W      = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 15;
   localparam int CMD_DEPTH   = 4;
   localparam int RSP_DEPTH   = 8;

   localparam logic [LAST_W-1:0] LAST_RESET = 15'd11025;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd51;

   // saturation bounds of the sum, 8 fraction bits
   localparam logic signed [STORE_W:0] CLAMP_HI = 26'sd8388352;
   localparam logic signed [STORE_W:0] CLAMP_LO = -26'sd8388352;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY_LAST = 2'd0,
      CSR_GAIN       = 2'd1,
      CSR_BYPASS     = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic                       bypass;
      logic signed [SAMPLE_W-1:0] sample;
   } fed_cmd_type;

endpackage

// ===== src/fed_fifo.sv =====
// Small flop-based FIFO queue with power-of-two depth.
module fed_fifo #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW:0]      wr_ff, wr_in;
   logic [AW:0]      rd_ff, rd_in;

   assign empty    = (wr_ff == rd_ff);
   assign full     = (wr_ff[AW] != rd_ff[AW]) && (wr_ff[AW-1:0] == rd_ff[AW-1:0]);
   assign pop_data = mem_ff[rd_ff[AW-1:0]];
   assign wr_in    = push ? wr_ff + (AW+1)'(1) : wr_ff;
   assign rd_in    = pop  ? rd_ff + (AW+1)'(1) : rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff[AW-1:0]] <= push_data;
      end
   end

endmodule

// ===== src/fed_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fed_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

endmodule

// ===== src/fed_front.sv =====
// Front end: accepts samples, tags each with its store index and, outside bypass, advances the pointer.
module fed_front #(
   parameter int STORE_DEPTH = fed_pkg::STORE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [fed_pkg::SAMPLE_W-1:0]   req_tdata,
   input  logic [fed_pkg::LAST_W-1:0]     delay_last_index,
   input  logic                           bypass,
   input  logic                           clearing,
   input  logic                           cmd_full,
   output logic                           cmd_push,
   output logic [$clog2(STORE_DEPTH)-1:0] cmd_idx,
   output fed_pkg::fed_cmd_type           cmd
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = (AW > fed_pkg::LAST_W) ? AW : fed_pkg::LAST_W;
   localparam logic [CW-1:0] LAST_MAX = CW'(STORE_DEPTH - 1);

   logic [AW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] last_ext, last_eff, ptr_ext;

   assign last_ext = CW'(delay_last_index);
   assign last_eff = (last_ext > LAST_MAX) ? LAST_MAX : last_ext;
   assign ptr_ext  = CW'(ptr_ff);

   assign req_tready = !cmd_full && !clearing;
   assign cmd_push   = req_tvalid && req_tready;
   assign cmd_idx    = ptr_ff;
   assign cmd.bypass = bypass;
   assign cmd.sample = $signed(req_tdata);

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd_push && !bypass) begin
         ptr_in = (ptr_ext < last_eff) ? ptr_ff + AW'(1) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

endmodule

// ===== src/fed_back.sv =====
// Back end: store read-modify-write pipeline, clearing sweep and result queue.
module fed_back #(
   parameter int STORE_DEPTH = fed_pkg::STORE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [fed_pkg::GAIN_W-1:0]          gain_code,
   input  logic                                clear_start,
   output logic                                clearing,
   input  logic                                cmd_empty,
   input  logic [$clog2(STORE_DEPTH)-1:0]      cmd_idx,
   input  fed_pkg::fed_cmd_type                cmd,
   output logic                                cmd_pop,
   output logic                                ram_we,
   output logic [$clog2(STORE_DEPTH)-1:0]      ram_waddr,
   output logic [fed_pkg::STORE_W-1:0]         ram_wdata,
   output logic [$clog2(STORE_DEPTH)-1:0]      ram_raddr,
   input  logic signed [fed_pkg::STORE_W-1:0]  ram_rdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [fed_pkg::SAMPLE_W-1:0]        rsp_tdata
);

   localparam int AW  = $clog2(STORE_DEPTH);
   localparam int SW  = fed_pkg::SAMPLE_W;
   localparam int TW  = fed_pkg::STORE_W;
   localparam int CRW = $clog2(fed_pkg::RSP_DEPTH + 1);

   // clearing sweep
   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // issue and credits
   logic           hazard, credit_ok, issue, rsp_pop, rsp_empty;
   logic [CRW-1:0] credits_ff, credits_in;

   // stage 1: store data arrives
   logic                 v1_ff, b1_ff;
   logic [AW-1:0]        i1_ff;
   logic signed [SW-1:0] x1_ff;
   logic signed [23:0]   xq;
   logic signed [TW:0]   sum_raw, sum_cl, y_round, t_full;

   // stage 2: feedback term
   logic                 v2_ff, b2_ff;
   logic [AW-1:0]        i2_ff;
   logic [SW-1:0]        y2_ff, y2_in;
   logic signed [TW-1:0] t2_ff;
   logic [TW-1:0]        t2_neg;
   logic [23:0]          mag;

   // stage 3: product
   logic          v3_ff, b3_ff, n3_ff;
   logic [AW-1:0] i3_ff;
   logic [SW-1:0] y3_ff;
   logic [31:0]   p3_ff;
   logic [TW-1:0] q0;
   logic [33:0]   r_full;

   // stage 4: divide-by-255 fix-up and write back
   logic          v4_ff, b4_ff, n4_ff;
   logic [AW-1:0] i4_ff;
   logic [SW-1:0] y4_ff;
   logic [23:0]   q4_ff, q;
   logic [11:0]   r4_ff;
   logic [12:0]   corr;
   logic [TW-1:0] fb;

   assign clearing = clearing_ff;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_start) begin
         clearing_in = 1'b1;
         clr_addr_in = '0;
      end else if (clearing_ff) begin
         if (clr_addr_ff == AW'(STORE_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
         clr_addr_in = clr_addr_ff + AW'(1);
      end
   end

   // a non-bypass item waits while an earlier non-bypass one with the same index is still in flight
   assign hazard = !cmd.bypass && (
      (v1_ff && !b1_ff && i1_ff == cmd_idx) ||
      (v2_ff && !b2_ff && i2_ff == cmd_idx) ||
      (v3_ff && !b3_ff && i3_ff == cmd_idx) ||
      (v4_ff && !b4_ff && i4_ff == cmd_idx));
   assign credit_ok = credits_ff < CRW'(fed_pkg::RSP_DEPTH);
   assign issue     = !cmd_empty && !clearing_ff && !hazard && credit_ok;
   assign cmd_pop   = issue;
   assign ram_raddr = cmd_idx;
   assign rsp_pop   = rsp_tvalid && rsp_tready;

   always_comb begin
      unique case ({issue, rsp_pop})
         2'b10:   credits_in = credits_ff + CRW'(1);
         2'b01:   credits_in = credits_ff - CRW'(1);
         default: credits_in = credits_ff;
      endcase
   end

   // stage 1 datapath
   assign xq      = $signed({x1_ff, 8'd0});
   assign sum_raw = (TW+1)'(ram_rdata) + (TW+1)'(xq);
   always_comb begin
      if (sum_raw > fed_pkg::CLAMP_HI) begin
         sum_cl = fed_pkg::CLAMP_HI;
      end else if (sum_raw < fed_pkg::CLAMP_LO) begin
         sum_cl = fed_pkg::CLAMP_LO;
      end else begin
         sum_cl = sum_raw;
      end
   end
   assign y_round = sum_cl[TW] ? sum_cl + (TW+1)'(255) : sum_cl;
   assign t_full  = (TW+1)'(xq) + sum_cl;
   assign y2_in   = b1_ff ? x1_ff : y_round[23:8];

   // stage 2 datapath
   assign t2_neg = -t2_ff;
   assign mag    = t2_ff[TW-1] ? t2_neg[23:0] : t2_ff[23:0];

   // stage 3 datapath: q0 underestimates p/255 by at most a few units
   assign q0     = TW'(p3_ff[31:8]) + TW'(p3_ff[31:16]) + TW'(p3_ff[31:24]);
   assign r_full = 34'(p3_ff) + 34'(q0) - (34'(q0) << 8);

   // stage 4 datapath
   assign corr = (13'(r4_ff) + 13'd1 + 13'(r4_ff[11:8])) >> 8;
   assign q    = q4_ff + 24'(corr[4:0]);
   assign fb   = n4_ff ? -TW'(q) : TW'(q);

   assign ram_we    = clearing_ff || (v4_ff && !b4_ff);
   assign ram_waddr = clearing_ff ? clr_addr_ff : i4_ff;
   assign ram_wdata = clearing_ff ? '0 : fb;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         credits_ff  <= '0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         v4_ff       <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
         credits_ff  <= credits_in;
         v1_ff       <= issue;
         v2_ff       <= v1_ff;
         v3_ff       <= v2_ff;
         v4_ff       <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff <= cmd.sample;
      i1_ff <= cmd_idx;
      b1_ff <= cmd.bypass;

      y2_ff <= y2_in;
      t2_ff <= t_full[TW-1:0];
      i2_ff <= i1_ff;
      b2_ff <= b1_ff;

      p3_ff <= 32'(mag) * 32'(gain_code);
      n3_ff <= t2_ff[TW-1];
      y3_ff <= y2_ff;
      i3_ff <= i2_ff;
      b3_ff <= b2_ff;

      q4_ff <= q0[23:0];
      r4_ff <= r_full[11:0];
      n4_ff <= n3_ff;
      y4_ff <= y3_ff;
      i4_ff <= i3_ff;
      b4_ff <= b3_ff;
   end

   fed_fifo #(
      .WIDTH (SW),
      .DEPTH (fed_pkg::RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (v4_ff),
      .push_data (y4_ff),
      .pop       (rsp_pop),
      .pop_data  (rsp_tdata),
      .empty     (rsp_empty),
      .full      ()
   );

   assign rsp_tvalid = !rsp_empty;

endmodule

// ===== src/feedback_echo_delay_top.sv =====
// Top level of the feedback echo delay block.
//
//  port group | dir | transaction payload
//  req_*      | in  | tdata[15:0] sample_in
//  rsp_*      | out | tdata[15:0] sample_out
//  csr_*      | in  | index 0 delay_last_index, 1 gain_code, 2 bypass
//
// One sample per cycle while not stalled; an accepted sample passes through the command
// queue and the four store pipeline stages into the result queue.
// A non-bypass sample whose store index is still in the four-stage store pipeline waits,
// so with a last index L below four an index returns while still in flight and issue stalls.
// After reset and after every bypass write a clearing pass zeroes every store entry,
// during which req_tready is low. Results queue in an 8-deep FIFO.
`include "feedback_echo_delay_top_defines.svh"

module feedback_echo_delay_top #(
   parameter int STORE_DEPTH = fed_pkg::STORE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [fed_pkg::SAMPLE_W-1:0]     req_tdata,   // [15:0] sample_in
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fed_pkg::SAMPLE_W-1:0]     rsp_tdata,   // [15:0] sample_out
   input  logic                             csr_we,
   input  logic [fed_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fed_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int AW    = $clog2(STORE_DEPTH);
   localparam int CMD_W = AW + $bits(fed_pkg::fed_cmd_type);

   logic [fed_pkg::LAST_W-1:0] last_ff;
   logic [fed_pkg::GAIN_W-1:0] gain_ff;
   logic                       bypass_ff;
   logic                       bypass_write;

   logic                 clearing;
   logic                 cmd_push, cmd_pop, cmd_full, cmd_empty;
   logic [AW-1:0]        push_idx, head_idx;
   fed_pkg::fed_cmd_type push_cmd, head_cmd;
   logic [CMD_W-1:0]     head_data;

   logic                        ram_we;
   logic [AW-1:0]               ram_waddr, ram_raddr;
   logic [fed_pkg::STORE_W-1:0] ram_wdata, ram_rdata;

   assign bypass_write = csr_we && (csr_index == fed_pkg::CSR_BYPASS);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= fed_pkg::LAST_RESET;
         gain_ff   <= fed_pkg::GAIN_RESET;
         bypass_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            fed_pkg::CSR_DELAY_LAST: last_ff   <= csr_wdata[fed_pkg::LAST_W-1:0];
            fed_pkg::CSR_GAIN:       gain_ff   <= csr_wdata[fed_pkg::GAIN_W-1:0];
            fed_pkg::CSR_BYPASS:     bypass_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   fed_front #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .delay_last_index (last_ff),
      .bypass           (bypass_ff),
      .clearing         (clearing),
      .cmd_full         (cmd_full),
      .cmd_push         (cmd_push),
      .cmd_idx          (push_idx),
      .cmd              (push_cmd)
   );

   fed_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (fed_pkg::CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data ({push_idx, push_cmd}),
      .pop       (cmd_pop),
      .pop_data  (head_data),
      .empty     (cmd_empty),
      .full      (cmd_full)
   );

   assign head_idx = head_data[CMD_W-1 -: AW];
   assign head_cmd = head_data[$bits(fed_pkg::fed_cmd_type)-1:0];

   fed_back #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .gain_code   (gain_ff),
      .clear_start (bypass_write),
      .clearing    (clearing),
      .cmd_empty   (cmd_empty),
      .cmd_idx     (head_idx),
      .cmd         (head_cmd),
      .cmd_pop     (cmd_pop),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_raddr   (ram_raddr),
      .ram_rdata   (ram_rdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   fed_ram #(
      .WIDTH (fed_pkg::STORE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   `FED_ASSERT_SAME(a_no_req_in_clear, clearing, !req_tready, "sample taken during clear")
   `FED_ASSERT_NEXT(a_bypass_clears, bypass_write, clearing, "bypass write did not clear")
   `FED_ASSERT_SAME(a_clear_zero, clearing, ram_we && ram_wdata == '0, "clear wrote nonzero")

endmodule
